FILE: hw/rtl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, character constants and helper functions for the HTTP
// request line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrlp_pkg;

  localparam int PATH_MAX_DEFAULT    = 256;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Most decoded path bytes that one request byte can release.
  localparam int MAX_PATH_ITEMS = 3;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_QUERY   = 8'h3F;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_VT      = 8'h0B;
  localparam logic [7:0] CHAR_FF      = 8'h0C;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  localparam logic ITEM_PATH   = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  // Method matcher progress: 0..3 characters of GET seen, then a verdict.
  localparam logic [2:0] MM_NONE    = 3'd0;
  localparam logic [2:0] MM_FULL    = 3'd3;
  localparam logic [2:0] MM_IS_GET  = 3'd4;
  localparam logic [2:0] MM_NOT_GET = 3'd5;

  localparam logic [1:0] ESC_IDLE    = 2'd0;
  localparam logic [1:0] ESC_PERCENT = 2'd1;
  localparam logic [1:0] ESC_DIGIT   = 2'd2;

  typedef enum logic [1:0] {
    PH_METHOD,
    PH_PATH,
    PH_REST,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_SPACE,
    ST_NO_PATH_END
  } status_e;

  // Work handed from the parser to the output side for one request byte.
  typedef struct packed {
    logic [1:0]                          n_path;
    logic [MAX_PATH_ITEMS-1:0][7:0]      path;
    logic                                last;
    status_e                             status;
    logic                                get;
  } pkt_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic is_method_end(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR) || (c == CHAR_NUL);
  endfunction

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h47;
      2'd1:    r = 8'h45;
      2'd2:    r = 8'h54;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hrlp_front.sv
// ----------------------------------------------------------------------------
// hrlp_front
// Parser front end: takes one request byte per transaction, tracks the method
// match, the request line phase and the percent escape, and pushes one work
// packet per byte that releases path bytes or ends the request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlp_front import hrlp_pkg::*; #(
  parameter int PathMax = PATH_MAX_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] request_byte_i,
  input  wire logic       end_of_request_i,
  input  wire logic       full_i,
  output logic            push_o,
  output pkt_t            pkt_o
);

  localparam int LW = $clog2(PathMax + 1);
  localparam logic [LW-1:0] LenMax = LW'(PathMax);

  phase_e      phase_q, phase_d;
  logic [LW-1:0] line_pos_q, line_pos_d;
  logic [LW-1:0] path_len_q, path_len_d;
  logic [2:0]  mm_q, mm_d;
  logic [1:0]  esc_q, esc_d;
  logic [7:0]  held_q, held_d;
  status_e     status_q, status_d;
  logic        get_q, get_d;

  logic        accept;
  logic [1:0]  n_path;
  logic [3:0][7:0] path_bytes;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [7:0] c;
    logic [1:0] pn;
    logic [3:0][7:0] pb;
    logic       taken;
    c     = request_byte_i;
    pn    = 2'd0;
    pb    = '0;
    taken = 1'b0;

    phase_d    = phase_q;
    line_pos_d = line_pos_q;
    path_len_d = path_len_q;
    mm_d       = mm_q;
    esc_d      = esc_q;
    held_d     = held_q;
    status_d   = status_q;
    get_d      = get_q;

    // Method token against GET.
    if (mm_q < MM_IS_GET) begin
      if (is_method_end(c)) begin
        mm_d  = (mm_q == MM_FULL) ? MM_IS_GET : MM_NOT_GET;
        get_d = (mm_q == MM_FULL);
      end else if ((mm_q < MM_FULL) && (c == get_char(mm_q[1:0]))) begin
        mm_d = mm_q + 3'd1;
      end else begin
        mm_d = MM_NOT_GET;
      end
    end

    if (phase_q != PH_DONE) begin
      if ((line_pos_q >= LenMax) || (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_NUL)) begin
        case (phase_q)
          PH_METHOD: status_d = ST_NO_SPACE;
          PH_PATH:   status_d = ST_NO_PATH_END;
          PH_REST:   status_d = ST_OK;
          default:   status_d = status_q;
        endcase
        esc_d   = ESC_IDLE;
        phase_d = PH_DONE;
      end else begin
        line_pos_d = line_pos_q + LW'(1);
        case (phase_q)
          PH_METHOD: begin
            if (c == CHAR_SPACE) begin
              phase_d = PH_PATH;
            end
          end
          PH_PATH: begin
            if ((c == CHAR_SPACE) || (c == CHAR_QUERY)) begin
              // An escape still open at the path end goes out literally.
              if (esc_q == ESC_PERCENT) begin
                pb[pn] = CHAR_PERCENT;
                pn     = pn + 2'd1;
              end else if (esc_q == ESC_DIGIT) begin
                pb[pn] = CHAR_PERCENT;
                pn     = pn + 2'd1;
                pb[pn] = held_q;
                pn     = pn + 2'd1;
              end
              esc_d   = ESC_IDLE;
              phase_d = PH_REST;
            end else begin
              path_len_d = path_len_q + LW'(1);
              if (path_len_d >= LenMax) begin
                status_d = ST_NO_PATH_END;
                esc_d    = ESC_IDLE;
                phase_d  = PH_DONE;
              end else begin
                if (esc_q == ESC_PERCENT) begin
                  if (is_hex(c)) begin
                    held_d = c;
                    esc_d  = ESC_DIGIT;
                    taken  = 1'b1;
                  end else begin
                    pb[pn] = CHAR_PERCENT;
                    pn     = pn + 2'd1;
                  end
                end else if (esc_q == ESC_DIGIT) begin
                  if (is_hex(c)) begin
                    pb[pn] = {hex_value(held_q), hex_value(c)};
                    pn     = pn + 2'd1;
                    esc_d  = ESC_IDLE;
                    taken  = 1'b1;
                  end else begin
                    pb[pn] = CHAR_PERCENT;
                    pn     = pn + 2'd1;
                    pb[pn] = held_q;
                    pn     = pn + 2'd1;
                  end
                end
                if (!taken) begin
                  esc_d = ESC_IDLE;
                  if (c == CHAR_PERCENT) begin
                    esc_d = ESC_PERCENT;
                  end else if (c == CHAR_PLUS) begin
                    pb[pn] = CHAR_SPACE;
                    pn     = pn + 2'd1;
                  end else begin
                    pb[pn] = c;
                    pn     = pn + 2'd1;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (end_of_request_i) begin
      if (phase_d != PH_DONE) begin
        case (phase_d)
          PH_METHOD: status_d = ST_NO_SPACE;
          PH_PATH:   status_d = ST_NO_PATH_END;
          default:   status_d = ST_OK;
        endcase
        phase_d = PH_DONE;
      end
      if (mm_d < MM_IS_GET) begin
        get_d = (mm_d == MM_FULL);
      end
      // Path bytes of a failed request are dropped at its final byte.
      if (status_d != ST_OK) begin
        pn = 2'd0;
      end
    end

    n_path     = pn;
    path_bytes = pb;
  end

  always_comb begin
    pkt_o.n_path = n_path;
    pkt_o.path   = path_bytes[MAX_PATH_ITEMS-1:0];
    pkt_o.last   = end_of_request_i;
    pkt_o.status = end_of_request_i ? status_d : ST_OK;
    pkt_o.get    = end_of_request_i ? get_d : 1'b0;
    push_o       = accept && ((n_path != 2'd0) || end_of_request_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_METHOD;
      line_pos_q <= '0;
      path_len_q <= '0;
      mm_q       <= MM_NONE;
      esc_q      <= ESC_IDLE;
      held_q     <= '0;
      status_q   <= ST_OK;
      get_q      <= 1'b0;
    end else if (accept) begin
      if (end_of_request_i) begin
        phase_q    <= PH_METHOD;
        line_pos_q <= '0;
        path_len_q <= '0;
        mm_q       <= MM_NONE;
        esc_q      <= ESC_IDLE;
        held_q     <= '0;
        status_q   <= ST_OK;
        get_q      <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        line_pos_q <= line_pos_d;
        path_len_q <= path_len_d;
        mm_q       <= mm_d;
        esc_q      <= esc_d;
        held_q     <= held_d;
        status_q   <= status_d;
        get_q      <= get_d;
      end
    end
  end

  // A failed request never carries path bytes on its final packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && pkt_o.last && (pkt_o.status != ST_OK)) |-> (pkt_o.n_path == 2'd0))
    else $error("error status packet carries path bytes");

  // The final byte returns the parser to the start of a new request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_request_i) |=>
      ((phase_q == PH_METHOD) && (line_pos_q == '0) && (mm_q == MM_NONE)))
    else $error("parser state not cleared after final byte");

  // Once the line is over, only the final byte leaves the done phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_DONE) && !(accept && end_of_request_i)) |=> (phase_q == PH_DONE))
    else $error("left done phase without final byte");

endmodule

`default_nettype wire

FILE: hw/rtl/hrlp_queue.sv
// ----------------------------------------------------------------------------
// hrlp_queue
// Short first-in first-out queue of work packets between the parser front
// end and the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlp_queue import hrlp_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  pkt_t      push_pkt_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output pkt_t      head_pkt_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] CntFull = CW'(Depth);

  pkt_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_pkt_o   = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == LastIdx) ? '0 : wr_q + AW'(1)) : wr_q;
    rd_d  = do_pop ? ((rd_q == LastIdx) ? '0 : rd_q + AW'(1)) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_pkt_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hrlp_back.sv
// ----------------------------------------------------------------------------
// hrlp_back
// Output side: walks the packet at the head of the queue and presents its path
// bytes, then its status item if it ends a request, one per cycle while out_ready_i allows, from an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlp_back import hrlp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic head_valid_i,
  input  pkt_t      head_pkt_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic       item_kind_o,
  output logic [7:0] path_byte_o,
  output logic [1:0] parse_status_o,
  output logic       method_is_get_o,
  output logic       last_item_o
);

  logic       out_valid_q, out_valid_d;
  logic       kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic [1:0] status_q, status_d;
  logic       get_q, get_d;
  logic       last_q, last_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic [2:0] total;

  assign total = {1'b0, head_pkt_i.n_path} + {2'b00, head_pkt_i.last};
  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && (({1'b0, idx_q} + 3'd1) == total);

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    byte_d      = byte_q;
    status_d    = status_q;
    get_d       = get_q;
    last_d      = last_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = pop_o ? 2'd0 : idx_q + 2'd1;
      if (idx_q < head_pkt_i.n_path) begin
        kind_d   = ITEM_PATH;
        byte_d   = head_pkt_i.path[idx_q];
        status_d = ST_OK;
        get_d    = 1'b0;
        last_d   = 1'b0;
      end else begin
        kind_d   = ITEM_STATUS;
        byte_d   = 8'h00;
        status_d = head_pkt_i.status;
        get_d    = head_pkt_i.get;
        last_d   = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    status_q <= status_d;
    get_q    <= get_d;
    last_q   <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign item_kind_o     = kind_q;
  assign path_byte_o     = byte_q;
  assign parse_status_o  = status_q;
  assign method_is_get_o = get_q;
  assign last_item_o     = last_q;

  // The cursor stays inside a packet and is back at zero when nothing waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd3) && (head_valid_i || (idx_q == 2'd0)))
    else $error("packet cursor out of range");

  // A packet leaves the queue only when its last item is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (head_valid_i && (total != 3'd0)))
    else $error("pop without a complete packet");

endmodule

`default_nettype wire

FILE: hw/rtl/http_request_line_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_core
// HTTP request line parser: checks the method for GET, extracts and
// percent-decodes the path, and ends each request with a status item.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake                Payload
//   input    in   in_valid_i / in_ready_o  request_byte_i, end_of_request_i
//   output   out  out_valid_o / out_ready_i item_kind_o, path_byte_o,
//                                          parse_status_o, method_is_get_o,
//                                          last_item_o
//
// One request byte is taken per cycle while the packet queue has room.
// The output register gives one item per cycle while out_ready_i allows; a byte
// that releases two or three items keeps the output side on its packet until all have gone out.
// The queue of QueueDepth packets lets input and output stall independently.
// After reset the parser is ready at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_parser_core import hrlp_pkg::*; #(
  parameter int PathMax    = PATH_MAX_DEFAULT,
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] request_byte_i,
  input  wire logic       end_of_request_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            item_kind_o,
  output logic [7:0]      path_byte_o,
  output logic [1:0]      parse_status_o,
  output logic            method_is_get_o,
  output logic            last_item_o
);

  logic push, full, pop, head_valid;
  pkt_t push_pkt, head_pkt;

  hrlp_front #(
    .PathMax(PathMax)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .request_byte_i  (request_byte_i),
    .end_of_request_i(end_of_request_i),
    .full_i          (full),
    .push_o          (push),
    .pkt_o           (push_pkt)
  );

  hrlp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_pkt_i  (push_pkt),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_pkt_o  (head_pkt)
  );

  hrlp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_pkt_i     (head_pkt),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .item_kind_o    (item_kind_o),
    .path_byte_o    (path_byte_o),
    .parse_status_o (parse_status_o),
    .method_is_get_o(method_is_get_o),
    .last_item_o    (last_item_o)
  );

endmodule

`default_nettype wire
